// ===== hw/rtl/rtpfp_pkg.sv =====
// Shared types and constants for the RTP frame packetizer.
// No dependencies; used by every module of the block.
package rtpfp_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SSRC = 2'd0;
   localparam logic [1:0] CSR_PTYPE = 2'd1;

   // header layout: 12-byte RTP header plus 8-byte extension
   localparam int HDR_BYTES = 20;
   localparam int HDR_IDX_W = 5;

   localparam logic [7:0] HDR_VPXCC = 8'h90;   // V=2, X=1, CC=0
   localparam logic [7:0] EXT_PROFILE_HI = 8'hBE;
   localparam logic [7:0] EXT_PROFILE_LO = 8'hDE;
   localparam logic [7:0] EXT_LEN_HI = 8'h00;
   localparam logic [7:0] EXT_LEN_LO = 8'h01;
   localparam logic [7:0] EXT_ELEM_ID_LEN = 8'h32;  // id 3, length field 2

   typedef struct packed {
      logic [31:0] ssrc;
      logic [6:0] ptype;
   } cfg_type;

   // one classified input item, front to back
   typedef struct packed {
      logic hdr;            // packet start: header goes out first
      logic marker;
      logic [15:0] seq;
      logic [31:0] stamp;
      logic [23:0] ast;
      logic [7:0] data;
      logic pend;
      logic fend;
   } desc_type;

endpackage

// ===== hw/rtl/rtp_frame_packetizer_core.sv =====
// RTP frame packetizer top level: classifier, descriptor queue, serializer.
// Order: at a packet start the header bytes go out first, then the payload
// byte; a transaction inside a packet gives its payload byte alone.
// Throughput, while pop is held: one output byte per cycle from the serializer;
// one transaction per cycle inside a packet, while a packet start stays queued through its header.
// Synchronous reset clears counters, registers, queue and output stage.
module rtp_frame_packetizer_core #(
   parameter int PACKET_PAYLOAD_BYTES = 1200,
   parameter int QUEUE_DEPTH = 4
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [7:0] req_data_byte,
   input logic [15:0] req_frame_bytes,
   input logic [31:0] req_time_us,
   output logic empty,
   input logic pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_packet_end,
   output logic rsp_frame_end,
   output logic rsp_is_payload,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [31:0] csr_wdata
);

   rtpfp_pkg::cfg_type cfg_ff, cfg_in;
   rtpfp_pkg::desc_type new_desc, head_desc;
   logic accept, head_valid, head_pop, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rtpfp_pkg::CSR_SSRC: cfg_in.ssrc = csr_wdata;
            rtpfp_pkg::CSR_PTYPE: cfg_in.ptype = csr_wdata[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = push && !full;
   assign head_valid = !q_empty;

   rtpfp_classifier #(
      .PACKET_PAYLOAD_BYTES(PACKET_PAYLOAD_BYTES)
   ) u_classifier (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .data_byte(req_data_byte),
      .frame_bytes(req_frame_bytes),
      .time_us(req_time_us),
      .desc(new_desc)
   );

   rtpfp_desc_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .wr_desc(new_desc),
      .full(full),
      .pop(head_pop),
      .rd_desc(head_desc),
      .empty(q_empty)
   );

   rtpfp_serializer u_serializer (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .head(head_desc),
      .head_valid(head_valid),
      .head_pop(head_pop),
      .out_byte(rsp_out_byte),
      .packet_end(rsp_packet_end),
      .frame_end(rsp_frame_end),
      .is_payload(rsp_is_payload),
      .empty(empty),
      .pop(pop)
   );

   // frame end only ever lands on a packet's last byte
   a_fend_pend: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end) |-> rsp_packet_end)
      else $error("frame_end without packet_end");

   // header bytes never close a packet
   a_hdr_no_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_is_payload) |-> (!rsp_packet_end && !rsp_frame_end))
      else $error("packet_end on a header byte");

   // a header burst runs without gaps: its descriptor stays queued
   a_hdr_burst: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_is_payload) |=> !empty)
      else $error("gap inside header burst");

endmodule

// ===== hw/rtl/rtpfp_classifier.sv =====
// Front end: tracks frame and packet position, numbers packets and builds
// one descriptor per accepted transaction. Depends on rtpfp_pkg.
module rtpfp_classifier #(
   parameter int PACKET_PAYLOAD_BYTES = 1200
) (
   input logic clock,
   input logic reset,
   input logic accept,
   input logic [7:0] data_byte,
   input logic [15:0] frame_bytes,
   input logic [31:0] time_us,
   output rtpfp_pkg::desc_type desc
);

   localparam int CW = (PACKET_PAYLOAD_BYTES > 1) ? $clog2(PACKET_PAYLOAD_BYTES) : 1;
   localparam logic [16:0] PPB17 = 17'(PACKET_PAYLOAD_BYTES);
   localparam logic [CW:0] PPBC = (CW + 1)'(PACKET_PAYLOAD_BYTES);

   logic [15:0] seq_ff, seq_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [15:0] foff_ff, foff_in;
   logic [CW-1:0] chunk_ff, chunk_in;

   logic start, frame_start, fend, pend, marker;
   logic [15:0] seq_next;
   logic [31:0] stamp_use;

   always_comb begin
      start = (chunk_ff == '0);
      frame_start = (foff_ff == '0);
      seq_next = seq_ff + 16'd1;
      stamp_use = frame_start ? time_us : stamp_ff;
      marker = ({1'b0, frame_bytes} <= ({1'b0, foff_ff} + PPB17));
      fend = (({1'b0, foff_ff} + 17'd1) >= {1'b0, frame_bytes});
      pend = fend || (({1'b0, chunk_ff} + (CW + 1)'(1)) >= PPBC);

      desc.hdr = start;
      desc.marker = marker;
      desc.seq = seq_next;
      desc.stamp = stamp_use;
      desc.ast = time_us[23:0];
      desc.data = data_byte;
      desc.pend = pend;
      desc.fend = fend;

      seq_in = seq_ff;
      stamp_in = stamp_ff;
      foff_in = foff_ff;
      chunk_in = chunk_ff;
      if (accept) begin
         if (start) begin
            seq_in = seq_next;
            stamp_in = stamp_use;
         end
         foff_in = fend ? '0 : foff_ff + 16'd1;
         chunk_in = pend ? '0 : chunk_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         stamp_ff <= '0;
         foff_ff <= '0;
         chunk_ff <= '0;
      end else begin
         seq_ff <= seq_in;
         stamp_ff <= stamp_in;
         foff_ff <= foff_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

// ===== hw/rtl/rtpfp_desc_fifo.sv =====
// Short descriptor queue between classifier and serializer.
// Depends on rtpfp_pkg for the descriptor type.
module rtpfp_desc_fifo #(
   parameter int DEPTH = 4
) (
   input logic clock,
   input logic reset,
   input logic push,
   input rtpfp_pkg::desc_type wr_desc,
   output logic full,
   input logic pop,
   output rtpfp_pkg::desc_type rd_desc,
   output logic empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);

   rtpfp_pkg::desc_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full = (count_ff == DEPTH_C);
      empty = (count_ff == '0);
      do_push = push && !full;
      do_pop = pop && !empty;
      rd_desc = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      count_in = count_ff + CNTW'(do_push) - CNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/rtpfp_serializer.sv =====
// Back end: turns the head descriptor into header bytes and the payload
// byte, one per cycle into the output register while it is empty or popped. Depends on rtpfp_pkg.
module rtpfp_serializer (
   input logic clock,
   input logic reset,
   input rtpfp_pkg::cfg_type cfg,
   input rtpfp_pkg::desc_type head,
   input logic head_valid,
   output logic head_pop,
   output logic [7:0] out_byte,
   output logic packet_end,
   output logic frame_end,
   output logic is_payload,
   output logic empty,
   input logic pop
);

   localparam logic [rtpfp_pkg::HDR_IDX_W-1:0] HDR_END =
      rtpfp_pkg::HDR_IDX_W'(rtpfp_pkg::HDR_BYTES);

   logic [rtpfp_pkg::HDR_IDX_W-1:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic pend_ff, pend_in, fend_ff, fend_in, pay_ff, pay_in;
   logic load, emit_hdr;
   logic [7:0] hdr_byte;

   always_comb begin
      case (idx_ff)
         5'd0: hdr_byte = rtpfp_pkg::HDR_VPXCC;
         5'd1: hdr_byte = {head.marker, cfg.ptype};
         5'd2: hdr_byte = head.seq[15:8];
         5'd3: hdr_byte = head.seq[7:0];
         5'd4: hdr_byte = head.stamp[31:24];
         5'd5: hdr_byte = head.stamp[23:16];
         5'd6: hdr_byte = head.stamp[15:8];
         5'd7: hdr_byte = head.stamp[7:0];
         5'd8: hdr_byte = cfg.ssrc[31:24];
         5'd9: hdr_byte = cfg.ssrc[23:16];
         5'd10: hdr_byte = cfg.ssrc[15:8];
         5'd11: hdr_byte = cfg.ssrc[7:0];
         5'd12: hdr_byte = rtpfp_pkg::EXT_PROFILE_HI;
         5'd13: hdr_byte = rtpfp_pkg::EXT_PROFILE_LO;
         5'd14: hdr_byte = rtpfp_pkg::EXT_LEN_HI;
         5'd15: hdr_byte = rtpfp_pkg::EXT_LEN_LO;
         5'd16: hdr_byte = rtpfp_pkg::EXT_ELEM_ID_LEN;
         5'd17: hdr_byte = head.ast[23:16];
         5'd18: hdr_byte = head.ast[15:8];
         5'd19: hdr_byte = head.ast[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      load = !valid_ff || pop;
      emit_hdr = head.hdr && (idx_ff != HDR_END);
      head_pop = load && head_valid && !emit_hdr;

      idx_in = idx_ff;
      valid_in = valid_ff;
      byte_in = byte_ff;
      pend_in = pend_ff;
      fend_in = fend_ff;
      pay_in = pay_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (emit_hdr) begin
               idx_in = idx_ff + rtpfp_pkg::HDR_IDX_W'(1);
               byte_in = hdr_byte;
               pend_in = 1'b0;
               fend_in = 1'b0;
               pay_in = 1'b0;
            end else begin
               idx_in = '0;
               byte_in = head.data;
               pend_in = head.pend;
               fend_in = head.fend;
               pay_in = 1'b1;
            end
         end
      end

      out_byte = byte_ff;
      packet_end = pend_ff;
      frame_end = fend_ff;
      is_payload = pay_ff;
      empty = !valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pend_ff <= pend_in;
      fend_ff <= fend_in;
      pay_ff <= pay_in;
   end

endmodule
